[src/smaa_pkg.sv]
package smaa_pkg;

    // fixed field widths
    localparam int ROW_W  = 10;
    localparam int COL_W  = 10;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 12;
    localparam int USED_W = 13;
    localparam int RUSE_W = 11;

    // stream packing
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 4;

    typedef enum logic [1:0] {
        OP_ACCUM  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_RESET  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_ADDED     = 3'd0,
        STAT_APPENDED  = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_DONE      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        RES_HIT  = 3'd0,
        RES_NEW  = 3'd1,
        RES_MISS = 3'd2,
        RES_FULL = 3'd3,
        RES_DONE = 3'd4
    } res_kind_t;

    typedef enum logic [3:0] {
        S_INIT      = 4'd0,
        S_IDLE      = 4'd1,
        S_START     = 4'd2,
        S_HEAD      = 4'd3,
        S_WALK      = 4'd4,
        S_MISS      = 4'd5,
        S_APPEND    = 4'd6,
        S_LINK      = 4'd7,
        S_RESP      = 4'd8,
        S_CLR_RD    = 4'd9,
        S_CLR_HEAD  = 4'd10,
        S_CLR_WALK  = 4'd11,
        S_RST       = 4'd12
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic      capture;
        logic      head_sel_sweep;
        logic      ent_src_nxt;
        logic      walk_start;
        logic      walk_step;
        logic      acc_write;
        logic      clr_write;
        logic      append;
        logic      link_write;
        logic      sweep_clr;
        logic      sweep_inc;
        logic      head_zero;
        logic      count_clr;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_load;
    } smaa_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic row_out;
        logic nrows_zero;
        logic sweep_end_all;
        logic sweep_end_use;
        logic head_valid;
        logic nxt_valid;
        logic col_hit;
        logic store_full;
    } smaa_stat_t;

endpackage

[src/sparse_matrix_assembly_accumulator_top.sv]
// a request walks the row's list entry by entry until its column hits; on a miss, accumulate appends
// and links a new entry if the store has room; a row out of use gets a miss without a walk; the
// result waits while a pending result sees result tready low; clear values zeroes the value of each
// linked entry of every row in use; reset structure zeroes each head in use and frees all entries
// throughput: one item at a time, next transfer taken the cycle after the result is registered
// reset: after rst_n a clearing pass zeroes all ROWS row heads, one per cycle, tready held low
module sparse_matrix_assembly_accumulator_top
    import smaa_pkg::*;
#(
    parameter int ROWS    = 1024,
    parameter int ENTRIES = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // row[9:0], col[19:10], value[51:20]
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,  // operation[1:0]
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // result_value[31:0], entry_index[43:32],
                                                 // entries_used[56:44]
    output logic [M_TUSER_W-1:0]  m_axis_tuser,  // status[2:0], saturated[3]
    // rows_in_use register
    input  logic                  cfg_wr_en,
    input  logic [RUSE_W-1:0]     cfg_wr_data
);

    smaa_cmd_t               cmd;
    smaa_stat_t              stat;
    status_t                 out_status;
    logic signed [VAL_W-1:0] out_value;
    logic [IDX_W-1:0]        out_index;
    logic [USED_W-1:0]       out_used;
    logic                    out_sat;

    // sequencer: walks lists, sweeps rows, paces the output register
    smaa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // head and entry memories, entry counter, saturating adder, result registers
    smaa_dp #(
        .ROWS    (ROWS),
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_op       (s_axis_tuser[1:0]),
        .in_row      (s_axis_tdata[9:0]),
        .in_col      (s_axis_tdata[19:10]),
        .in_value    (s_axis_tdata[51:20]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_status  (out_status),
        .out_value   (out_value),
        .out_index   (out_index),
        .out_used    (out_used),
        .out_sat     (out_sat)
    );

    // pack the result, unused top bits tied low
    assign m_axis_tdata = {7'd0, out_used, out_index, out_value};
    assign m_axis_tuser = {out_sat, out_status};

`ifndef SYNTHESIS
    // one item in flight: ready drops right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while an item is in flight");

    // the output register is only loaded when free or being drained
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");

    // no allocation once the entry store is full
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !stat.store_full)
        else $error("entry allocated with full store");
`endif

endmodule

[src/smaa_dp.sv]
module smaa_dp
    import smaa_pkg::*;
#(
    parameter int ROWS    = 1024,
    parameter int ENTRIES = 4096
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  smaa_cmd_t                cmd,
    output smaa_stat_t               stat,
    input  logic [1:0]               in_op,
    input  logic [ROW_W-1:0]         in_row,
    input  logic [COL_W-1:0]         in_col,
    input  logic signed [VAL_W-1:0]  in_value,
    input  logic                     cfg_wr_en,
    input  logic [RUSE_W-1:0]        cfg_wr_data,
    output status_t                  out_status,
    output logic signed [VAL_W-1:0]  out_value,
    output logic [IDX_W-1:0]         out_index,
    output logic [USED_W-1:0]        out_used,
    output logic                     out_sat
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(ROWS + 1);
    localparam int NW = (CW > RUSE_W) ? CW : RUSE_W;
    localparam int EW = $clog2(ENTRIES);
    localparam int LW = $clog2(ENTRIES + 1);
    localparam logic [NW-1:0] ROWS_N    = NW'(ROWS);
    localparam logic [LW-1:0] ENTRIES_L = LW'(ENTRIES);

    // storage
    logic [LW-1:0]    head_mem [ROWS];
    logic [COL_W-1:0] col_mem  [ENTRIES];
    logic [VAL_W-1:0] val_mem  [ENTRIES];
    logic [LW-1:0]    nxt_mem  [ENTRIES];

    logic [LW-1:0]    head_rdata_reg;
    logic [COL_W-1:0] col_rdata_reg;
    logic [VAL_W-1:0] val_rdata_reg;
    logic [LW-1:0]    nxt_rdata_reg;

    // item and walk registers
    op_t              op_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [VAL_W-1:0] val_reg;
    logic [LW-1:0]    link_reg;
    logic [LW-1:0]    last_reg;

    // control registers
    logic [RUSE_W-1:0] ruse_reg;
    logic [LW-1:0]     count_reg;
    logic [RW-1:0]     row_cnt_reg;

    // staged result
    status_t          res_status_reg;
    logic [VAL_W-1:0] res_value_reg;
    logic [EW-1:0]    res_index_reg;
    logic             res_sat_reg;

    // output register
    status_t          out_status_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic [USED_W-1:0] out_used_reg;
    logic             out_sat_reg;

    logic [NW-1:0]    nrows;
    logic [NW-1:0]    ruse_ext;
    logic [NW-1:0]    row_cnt_inc;
    logic [LW-1:0]    ent_code;
    logic [EW-1:0]    ent_addr;
    logic [EW-1:0]    link_addr;
    logic [EW-1:0]    last_addr;
    logic [EW-1:0]    new_addr;
    logic [RW-1:0]    head_raddr;
    logic [RW-1:0]    head_waddr;
    logic [LW-1:0]    head_wdata;
    logic             head_we;
    logic [VAL_W:0]   sum_ext;
    logic             acc_sat;
    logic [VAL_W-1:0] acc_value;

    assign ruse_ext    = NW'(ruse_reg);
    assign nrows       = (ruse_ext < ROWS_N) ? ruse_ext : ROWS_N;
    assign row_cnt_inc = NW'(row_cnt_reg) + NW'(1);

    assign ent_code  = cmd.ent_src_nxt ? nxt_rdata_reg : head_rdata_reg;
    assign ent_addr  = EW'(ent_code - LW'(1));
    assign link_addr = EW'(link_reg - LW'(1));
    assign last_addr = EW'(last_reg - LW'(1));
    assign new_addr  = EW'(count_reg);

    // saturating q16.16 add
    assign sum_ext   = {val_rdata_reg[VAL_W-1], val_rdata_reg} + {val_reg[VAL_W-1], val_reg};
    assign acc_sat   = sum_ext[VAL_W] != sum_ext[VAL_W-1];
    assign acc_value = !acc_sat ? sum_ext[VAL_W-1:0] :
                       (sum_ext[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}});

    always_comb
    begin
        stat.op            = op_reg;
        stat.row_out       = NW'(row_reg) >= nrows;
        stat.nrows_zero    = nrows == '0;
        stat.sweep_end_all = row_cnt_inc == ROWS_N;
        stat.sweep_end_use = row_cnt_inc == nrows;
        // a link beyond the allocated count reads as end of list
        stat.head_valid    = (head_rdata_reg != '0) && (head_rdata_reg <= count_reg);
        stat.nxt_valid     = (nxt_rdata_reg != '0) && (nxt_rdata_reg <= count_reg);
        stat.col_hit       = col_rdata_reg == col_reg;
        stat.store_full    = count_reg == ENTRIES_L;
    end

    // row head memory
    assign head_raddr = cmd.head_sel_sweep ? row_cnt_reg : RW'(row_reg);
    assign head_waddr = cmd.head_zero ? row_cnt_reg : RW'(row_reg);
    assign head_wdata = cmd.head_zero ? '0 : count_reg;
    assign head_we    = cmd.head_zero || (cmd.link_write && (last_reg == '0));

    always_ff @(posedge clk)
    begin
        head_rdata_reg <= head_mem[head_raddr];
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
    end

    // entry column memory
    always_ff @(posedge clk)
    begin
        col_rdata_reg <= col_mem[ent_addr];
        if (cmd.append)
        begin
            col_mem[new_addr] <= col_reg;
        end
    end

    // entry value memory
    always_ff @(posedge clk)
    begin
        val_rdata_reg <= val_mem[ent_addr];
        if (cmd.append)
        begin
            val_mem[new_addr] <= val_reg;
        end
        else if (cmd.acc_write)
        begin
            val_mem[link_addr] <= acc_value;
        end
        else if (cmd.clr_write)
        begin
            val_mem[ent_addr] <= '0;
        end
    end

    // entry link memory
    always_ff @(posedge clk)
    begin
        nxt_rdata_reg <= nxt_mem[ent_addr];
        if (cmd.append)
        begin
            nxt_mem[new_addr] <= '0;
        end
        else if (cmd.link_write && (last_reg != '0))
        begin
            nxt_mem[last_addr] <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ruse_reg    <= RUSE_W'(ROWS);
            count_reg   <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ruse_reg <= cfg_wr_data;
            end
            if (cmd.count_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + LW'(1);
            end
            if (cmd.sweep_clr)
            begin
                row_cnt_reg <= '0;
            end
            else if (cmd.sweep_inc)
            begin
                row_cnt_reg <= row_cnt_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op_t'(in_op);
            row_reg <= in_row;
            col_reg <= in_col;
            val_reg <= in_value;
        end
        if (cmd.walk_start)
        begin
            last_reg <= '0;
            link_reg <= head_rdata_reg;
        end
        else if (cmd.walk_step)
        begin
            last_reg <= link_reg;
            link_reg <= nxt_rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_kind)
                RES_HIT:
                begin
                    res_status_reg <= STAT_ADDED;
                    res_index_reg  <= link_addr;
                    if (op_reg == OP_ACCUM)
                    begin
                        res_value_reg <= acc_value;
                        res_sat_reg   <= acc_sat;
                    end
                    else
                    begin
                        res_value_reg <= val_rdata_reg;
                        res_sat_reg   <= 1'b0;
                    end
                end
                RES_NEW:
                begin
                    res_status_reg <= STAT_APPENDED;
                    res_value_reg  <= val_reg;
                    res_index_reg  <= new_addr;
                    res_sat_reg    <= 1'b0;
                end
                RES_MISS:
                begin
                    res_status_reg <= STAT_NOT_FOUND;
                    res_value_reg  <= '0;
                    res_index_reg  <= '0;
                    res_sat_reg    <= 1'b0;
                end
                RES_FULL:
                begin
                    res_status_reg <= STAT_FULL;
                    res_value_reg  <= '0;
                    res_index_reg  <= '0;
                    res_sat_reg    <= 1'b0;
                end
                default:
                begin
                    res_status_reg <= STAT_DONE;
                    res_value_reg  <= '0;
                    res_index_reg  <= '0;
                    res_sat_reg    <= 1'b0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_index_reg  <= IDX_W'(res_index_reg);
            out_used_reg   <= USED_W'(count_reg);
            out_sat_reg    <= res_sat_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_index  = out_index_reg;
    assign out_used   = out_used_reg;
    assign out_sat    = out_sat_reg;

endmodule

[src/smaa_ctrl.sv]
module smaa_ctrl
    import smaa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  smaa_stat_t stat,
    output smaa_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                // zero every row head after reset
                cmd.head_zero = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (stat.sweep_end_all)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                unique case (stat.op)
                    OP_CLEAR:
                    begin
                        cmd.sweep_clr = 1'b1;
                        if (stat.nrows_zero)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_DONE;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            state_next = S_CLR_RD;
                        end
                    end
                    OP_RESET:
                    begin
                        cmd.sweep_clr = 1'b1;
                        cmd.count_clr = 1'b1;
                        if (stat.nrows_zero)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_DONE;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            state_next = S_RST;
                        end
                    end
                    default:
                    begin
                        if (stat.row_out)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_MISS;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            state_next = S_HEAD;
                        end
                    end
                endcase
            end
            S_HEAD:
            begin
                cmd.walk_start = 1'b1;
                state_next     = stat.head_valid ? S_WALK : S_MISS;
            end
            S_WALK:
            begin
                cmd.ent_src_nxt = 1'b1;
                if (stat.col_hit)
                begin
                    cmd.acc_write = stat.op == OP_ACCUM;
                    cmd.res_load  = 1'b1;
                    cmd.res_kind  = RES_HIT;
                    state_next    = S_RESP;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    if (!stat.nxt_valid)
                    begin
                        state_next = S_MISS;
                    end
                end
            end
            S_MISS:
            begin
                if (stat.op == OP_LOOKUP)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_MISS;
                    state_next   = S_RESP;
                end
                else if (stat.store_full)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_FULL;
                    state_next   = S_RESP;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                cmd.append   = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_NEW;
                state_next   = S_LINK;
            end
            S_LINK:
            begin
                cmd.link_write = 1'b1;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_CLR_RD:
            begin
                cmd.head_sel_sweep = 1'b1;
                state_next         = S_CLR_HEAD;
            end
            S_CLR_HEAD, S_CLR_WALK:
            begin
                cmd.ent_src_nxt = state_reg == S_CLR_WALK;
                if ((state_reg == S_CLR_HEAD) ? stat.head_valid : stat.nxt_valid)
                begin
                    cmd.clr_write = 1'b1;
                    state_next    = S_CLR_WALK;
                end
                else if (stat.sweep_end_use)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_DONE;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.sweep_inc = 1'b1;
                    state_next    = S_CLR_RD;
                end
            end
            S_RST:
            begin
                cmd.head_zero = 1'b1;
                if (stat.sweep_end_use)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_DONE;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.sweep_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule
